/* rtl/gcb_pkg.sv */
package gcb_pkg;

  // fixed field widths
  localparam int COORD_W   = 11;
  localparam int OFFSET_W  = 8;
  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 32;
  localparam int ADDR_W    = 19;
  localparam int HEIGHT_W  = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 10;

  // pipeline depth, last stage is the output register
  localparam int NUM_STAGES = 3;

  // default geometry
  localparam int DEF_SCREEN_WIDTH  = 640;
  localparam int DEF_WORDS_PER_ROW = 320;

  // configuration reset values
  localparam logic [BYTE_W-1:0]   RST_FONT_LUMA     = 8'd235;
  localparam logic [BYTE_W-1:0]   RST_FONT_BLUE     = 8'd128;
  localparam logic [BYTE_W-1:0]   RST_FONT_RED      = 8'd128;
  localparam logic [HEIGHT_W-1:0] RST_SCREEN_HEIGHT = 10'd480;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FONT_LUMA      = 3'd0,
    REG_FONT_BLUE_DIFF = 3'd1,
    REG_FONT_RED_DIFF  = 3'd2,
    REG_SCREEN_HEIGHT  = 3'd3,
    REG_FRAME_SELECT   = 3'd4
  } cfg_reg_t;

  // live configuration
  typedef struct packed {
    logic [BYTE_W-1:0]   font_luma;
    logic [BYTE_W-1:0]   font_blue_diff;
    logic [BYTE_W-1:0]   font_red_diff;
    logic [HEIGHT_W-1:0] screen_height;
    logic                frame_select;
  } cfg_t;

  // per-stage load strobes from the pipeline control
  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctl_t;

endpackage

/* rtl/gcb_pixel_if.sv */
interface gcb_pixel_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [gcb_pkg::COORD_W-1:0]    glyph_x;
  logic signed [gcb_pkg::COORD_W-1:0]    glyph_y;
  logic        [gcb_pkg::OFFSET_W-1:0]   column_offset;
  logic        [gcb_pkg::OFFSET_W-1:0]   row_offset;
  logic        [gcb_pkg::BYTE_W-1:0]     coverage;
  logic        [gcb_pkg::WORD_W-1:0]     old_word;

  modport source (output valid, glyph_x, glyph_y, column_offset, row_offset, coverage,
                  old_word, input ready);
  modport sink   (input valid, glyph_x, glyph_y, column_offset, row_offset, coverage,
                  old_word, output ready);
endinterface

/* rtl/gcb_result_if.sv */
interface gcb_result_if;
  logic                          valid;
  logic                          ready;
  logic                          write_enable;
  logic                          buffer_select;
  logic [gcb_pkg::ADDR_W-1:0]    word_address;
  logic [gcb_pkg::WORD_W-1:0]    new_word;

  modport source (output valid, write_enable, buffer_select, word_address, new_word,
                  input ready);
  modport sink   (input valid, write_enable, buffer_select, word_address, new_word,
                  output ready);
endinterface

/* rtl/gcb_cfg_if.sv */
interface gcb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [gcb_pkg::CFG_IDX_W-1:0]    index;
  logic [gcb_pkg::CFG_DAT_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/gcb_cfg_regs.sv */
module gcb_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  gcb_cfg_if.sink       cfg,
  output gcb_pkg::cfg_t regs
);
  import gcb_pkg::*;

  cfg_t regs_next;

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register decode
  always_comb begin
    regs_next = regs;
    if (cfg.valid) begin
      case (cfg.index)
        REG_FONT_LUMA:      regs_next.font_luma      = cfg.data[BYTE_W-1:0];
        REG_FONT_BLUE_DIFF: regs_next.font_blue_diff = cfg.data[BYTE_W-1:0];
        REG_FONT_RED_DIFF:  regs_next.font_red_diff  = cfg.data[BYTE_W-1:0];
        REG_SCREEN_HEIGHT:  regs_next.screen_height  = cfg.data[HEIGHT_W-1:0];
        REG_FRAME_SELECT:   regs_next.frame_select   = cfg.data[0];
        default:            regs_next = regs;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.font_luma      <= RST_FONT_LUMA;
      regs.font_blue_diff <= RST_FONT_BLUE;
      regs.font_red_diff  <= RST_FONT_RED;
      regs.screen_height  <= RST_SCREEN_HEIGHT;
      regs.frame_select   <= 1'b0;
    end else begin
      regs <= regs_next;
    end
  end
endmodule

/* rtl/gcb_pipe_ctrl.sv */
module gcb_pipe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output gcb_pkg::pipe_ctl_t ctl
);
  import gcb_pkg::*;

  logic [NUM_STAGES-1:0] stage_valid;
  logic [NUM_STAGES-1:0] stage_ready;

  // a stage takes a new word when empty or when its content moves on
  always_comb begin
    stage_ready[NUM_STAGES-1] = !stage_valid[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      stage_ready[i] = !stage_valid[i] || stage_ready[i+1];
    end
  end

  assign ctl.load  = stage_ready;
  assign in_ready  = stage_ready[0];
  assign out_valid = stage_valid[NUM_STAGES-1];

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_ready[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (stage_ready[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
    end
  end
endmodule

/* rtl/gcb_addr_path.sv */
module gcb_addr_path #(
  parameter int SCREEN_WIDTH  = gcb_pkg::DEF_SCREEN_WIDTH,
  parameter int WORDS_PER_ROW = gcb_pkg::DEF_WORDS_PER_ROW
) (
  input  logic                                 clk,
  input  gcb_pkg::pipe_ctl_t                   ctl,
  input  logic [gcb_pkg::HEIGHT_W-1:0]         screen_height,
  input  logic signed [gcb_pkg::COORD_W-1:0]   glyph_x,
  input  logic signed [gcb_pkg::COORD_W-1:0]   glyph_y,
  input  logic [gcb_pkg::OFFSET_W-1:0]         column_offset,
  input  logic [gcb_pkg::OFFSET_W-1:0]         row_offset,
  output logic                                 visible_s2,
  output logic [gcb_pkg::ADDR_W-1:0]           word_address
);
  import gcb_pkg::*;

  localparam int POS_W  = COORD_W + 1;
  localparam int WPR_W  = $clog2(WORDS_PER_ROW + 1);
  localparam int PROD_W = HEIGHT_W + WPR_W;
  localparam int HALF_W = COORD_W - 1;
  localparam int SUM_W  = (PROD_W + 1 > ADDR_W) ? PROD_W + 1 : ADDR_W;
  localparam int CMP_W  = 14;

  logic signed [POS_W-1:0] col_s1;
  logic signed [POS_W-1:0] row_s1;
  logic                    visible;
  logic [PROD_W-1:0]       prod_s2;
  logic [HALF_W-1:0]       half_s2;
  logic [SUM_W-1:0]        addr_sum;

  // stage 1: screen position
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      col_s1 <= POS_W'(glyph_x) + $signed({4'b0, column_offset});
      row_s1 <= POS_W'(glyph_y) + $signed({4'b0, row_offset});
    end
  end

  // clipping against the screen edges
  assign visible = !col_s1[POS_W-1] && !row_s1[POS_W-1] &&
                   (CMP_W'(col_s1[POS_W-2:0]) < CMP_W'(SCREEN_WIDTH)) &&
                   (CMP_W'(row_s1[POS_W-2:0]) < CMP_W'(screen_height));

  // stage 2: row times words per row
  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      visible_s2 <= visible;
      prod_s2    <= PROD_W'(row_s1[HEIGHT_W-1:0]) * PROD_W'(WORDS_PER_ROW);
      half_s2    <= col_s1[COORD_W-1:1];
    end
  end

  assign addr_sum = SUM_W'(prod_s2) + SUM_W'(half_s2);

  // stage 3: word address, zero when clipped
  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      word_address <= visible_s2 ? addr_sum[ADDR_W-1:0] : '0;
    end
  end
endmodule

/* rtl/gcb_blend_path.sv */
module gcb_blend_path (
  input  logic                               clk,
  input  gcb_pkg::pipe_ctl_t                 ctl,
  input  gcb_pkg::cfg_t                      regs,
  input  logic                               odd_column,
  input  logic [gcb_pkg::BYTE_W-1:0]         coverage,
  input  logic [gcb_pkg::WORD_W-1:0]         old_word,
  input  logic                               visible_s2,
  output logic                               write_enable,
  output logic                               buffer_select,
  output logic [gcb_pkg::WORD_W-1:0]         new_word
);
  import gcb_pkg::*;

  localparam int MIX_W = 2 * BYTE_W;
  localparam logic [BYTE_W-1:0] FULL_COV = 8'd255;
  localparam logic [MIX_W-1:0]  ROUND    = 16'd127;

  // floor(x / 255) for x up to 65279
  function automatic logic [BYTE_W-1:0] div255(input logic [MIX_W-1:0] x);
    logic [MIX_W:0] t;
    t = {1'b0, x} + (MIX_W+1)'(x[MIX_W-1:BYTE_W]) + 17'd1;
    return t[MIX_W-1:BYTE_W];
  endfunction

  function automatic logic [MIX_W-1:0] mix(input logic [BYTE_W-1:0] back,
                                           input logic [BYTE_W-1:0] fore,
                                           input logic [BYTE_W-1:0] cov);
    logic [MIX_W-1:0] a;
    logic [MIX_W-1:0] b;
    a = back * (FULL_COV - cov);
    b = fore * cov;
    return a + b + ROUND;
  endfunction

  logic               odd_s1;
  logic [BYTE_W-1:0]  cov_s1;
  logic [WORD_W-1:0]  old_s1;
  logic [BYTE_W-1:0]  luma_back;

  logic               odd_s2;
  logic               cov_on_s2;
  logic [WORD_W-1:0]  old_s2;
  logic [MIX_W-1:0]   y_mix_s2;
  logic [MIX_W-1:0]   cb_mix_s2;
  logic [MIX_W-1:0]   cr_mix_s2;

  logic [WORD_W-1:0]  blended;
  logic [BYTE_W-1:0]  y_new;

  // stage 1: capture the word
  always_ff @(posedge clk) begin
    if (ctl.load[0]) begin
      odd_s1 <= odd_column;
      cov_s1 <= coverage;
      old_s1 <= old_word;
    end
  end

  assign luma_back = odd_s1 ? old_s1[15:8] : old_s1[31:24];

  // stage 2: weighted sums with rounding
  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      odd_s2    <= odd_s1;
      cov_on_s2 <= (cov_s1 != '0);
      old_s2    <= old_s1;
      y_mix_s2  <= mix(luma_back, regs.font_luma, cov_s1);
      cb_mix_s2 <= mix(old_s1[23:16], regs.font_blue_diff, cov_s1);
      cr_mix_s2 <= mix(old_s1[7:0], regs.font_red_diff, cov_s1);
    end
  end

  // divide and merge back into the packed word
  always_comb begin
    y_new   = div255(y_mix_s2);
    blended = old_s2;
    if (odd_s2) begin
      blended[15:8] = y_new;
    end else begin
      blended[31:24] = y_new;
    end
    blended[23:16] = div255(cb_mix_s2);
    blended[7:0]   = div255(cr_mix_s2);
  end

  // stage 3: output register
  always_ff @(posedge clk) begin
    if (ctl.load[2]) begin
      write_enable  <= visible_s2 && cov_on_s2;
      buffer_select <= regs.frame_select;
      new_word      <= (visible_s2 && cov_on_s2) ? blended : old_s2;
    end
  end
endmodule

/* rtl/glyph_coverage_blend_ycbcr_top.sv */
// an accepted pixel word passes through stage 1, stage 2 and the output register to its result word
// throughput: one pixel per cycle, three register stages, each moves on when the next has room
// a full output stage holds while the sink stalls; earlier stages keep filling
// reset (rst, synchronous, active high) empties the pipeline and loads the
// default font colour, screen height and frame select
module glyph_coverage_blend_ycbcr_top #(
  parameter int SCREEN_WIDTH  = gcb_pkg::DEF_SCREEN_WIDTH,
  parameter int WORDS_PER_ROW = gcb_pkg::DEF_WORDS_PER_ROW
) (
  input  logic          clk,
  input  logic          rst,
  gcb_pixel_if.sink     pix,
  gcb_result_if.source  res,
  gcb_cfg_if.sink       cfg
);
  import gcb_pkg::*;

  cfg_t      regs;
  pipe_ctl_t ctl;
  logic      visible_s2;

  // configuration registers
  gcb_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // handshake and stage valid bits
  gcb_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .ctl       (ctl)
  );

  // clipping and word address
  gcb_addr_path #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .WORDS_PER_ROW (WORDS_PER_ROW)
  ) u_addr (
    .clk           (clk),
    .ctl           (ctl),
    .screen_height (regs.screen_height),
    .glyph_x       (pix.glyph_x),
    .glyph_y       (pix.glyph_y),
    .column_offset (pix.column_offset),
    .row_offset    (pix.row_offset),
    .visible_s2    (visible_s2),
    .word_address  (res.word_address)
  );

  // coverage blend of luma and shared chroma
  gcb_blend_path u_blend (
    .clk           (clk),
    .ctl           (ctl),
    .regs          (regs),
    .odd_column    (pix.glyph_x[0] ^ pix.column_offset[0]),
    .coverage      (pix.coverage),
    .old_word      (pix.old_word),
    .visible_s2    (visible_s2),
    .write_enable  (res.write_enable),
    .buffer_select (res.buffer_select),
    .new_word      (res.new_word)
  );
endmodule

/* test/glyph_coverage_blend_ycbcr_top_tb.sv */
module glyph_coverage_blend_ycbcr_top_tb;
  import gcb_pkg::*;

  localparam int SCR_W = DEF_SCREEN_WIDTH;
  localparam int WPR   = DEF_WORDS_PER_ROW;
  localparam int LIMIT = 200000;

  // one pixel word as seen on the input channel
  typedef struct {
    logic signed [COORD_W-1:0] glyph_x;
    logic signed [COORD_W-1:0] glyph_y;
    logic [OFFSET_W-1:0]       column_offset;
    logic [OFFSET_W-1:0]       row_offset;
    logic [BYTE_W-1:0]         coverage;
    logic [WORD_W-1:0]         old_word;
  } pixel_t;

  // one blended framebuffer word as seen on the result channel
  typedef struct {
    logic              write_enable;
    logic              buffer_select;
    logic [ADDR_W-1:0] word_address;
    logic [WORD_W-1:0] new_word;
  } blend_t;

  // blend predictor and queue of pending framebuffer writes
  class blend_scoreboard;
    logic [BYTE_W-1:0]   font_luma;
    logic [BYTE_W-1:0]   font_blue_diff;
    logic [BYTE_W-1:0]   font_red_diff;
    logic [HEIGHT_W-1:0] screen_height;
    logic                frame_select;
    blend_t              pending_words[$];
    int                  errors;
    int                  n_checked;
    int                  n_written;
    int                  n_clipped;
    int                  n_bare;

    function void reset_regs();
      font_luma      = RST_FONT_LUMA;
      font_blue_diff = RST_FONT_BLUE;
      font_red_diff  = RST_FONT_RED;
      screen_height  = RST_SCREEN_HEIGHT;
      frame_select   = 1'b0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] val);
      case (idx)
        REG_FONT_LUMA:      font_luma      = val[BYTE_W-1:0];
        REG_FONT_BLUE_DIFF: font_blue_diff = val[BYTE_W-1:0];
        REG_FONT_RED_DIFF:  font_red_diff  = val[BYTE_W-1:0];
        REG_SCREEN_HEIGHT:  screen_height  = val[HEIGHT_W-1:0];
        REG_FRAME_SELECT:   frame_select   = val[0];
        default: ;
      endcase
    endfunction

    // rounded blend of one byte toward the font colour
    function logic [BYTE_W-1:0] mix(logic [BYTE_W-1:0] back, logic [BYTE_W-1:0] fore,
                                    logic [BYTE_W-1:0] cov);
      int acc;
      acc = (int'(back) * (255 - int'(cov)) + int'(fore) * int'(cov) + 127) / 255;
      return acc[BYTE_W-1:0];
    endfunction

    function void note_pixel(pixel_t p);
      int     col;
      int     row;
      int     addr;
      blend_t w;
      col = int'(p.glyph_x) + int'(p.column_offset);
      row = int'(p.glyph_y) + int'(p.row_offset);
      w.write_enable  = 1'b0;
      w.buffer_select = frame_select;
      w.word_address  = '0;
      w.new_word      = p.old_word;
      if (col >= 0 && row >= 0 && col < SCR_W && row < int'(screen_height)) begin
        addr = row * WPR + col / 2;
        w.word_address = addr[ADDR_W-1:0];
        if (p.coverage != 0) begin
          // odd column owns the second luma byte
          if (col % 2 == 1) begin
            w.new_word[15:8] = mix(p.old_word[15:8], font_luma, p.coverage);
          end else begin
            w.new_word[31:24] = mix(p.old_word[31:24], font_luma, p.coverage);
          end
          w.new_word[23:16] = mix(p.old_word[23:16], font_blue_diff, p.coverage);
          w.new_word[7:0]   = mix(p.old_word[7:0], font_red_diff, p.coverage);
          w.write_enable    = 1'b1;
        end else begin
          n_bare++;
        end
      end else begin
        n_clipped++;
      end
      pending_words.push_back(w);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(blend_t got);
      blend_t want;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word we=%0b addr=%0h data=%08h",
                         got.write_enable, got.word_address, got.new_word));
        return;
      end
      want = pending_words.pop_front();
      n_checked++;
      if (got.write_enable !== want.write_enable)
        report($sformatf("write_enable got %0b want %0b", got.write_enable,
                         want.write_enable));
      if (got.buffer_select !== want.buffer_select)
        report($sformatf("buffer_select got %0b want %0b", got.buffer_select,
                         want.buffer_select));
      if (got.word_address !== want.word_address)
        report($sformatf("word_address got %0h want %0h", got.word_address,
                         want.word_address));
      if (got.new_word !== want.new_word)
        report($sformatf("new_word got %08h want %08h", got.new_word, want.new_word));
      if (want.write_enable)
        n_written++;
    endtask

    function int pending();
      return pending_words.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles;
  int   src_max;
  int   snk_max;
  int   n_settings;

  gcb_pixel_if  pix_ch();
  gcb_result_if res_ch();
  gcb_cfg_if    cfg_ch();

  blend_scoreboard sb = new();

  glyph_coverage_blend_ycbcr_top #(
    .SCREEN_WIDTH  (SCR_W),
    .WORDS_PER_ROW (WPR)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .pix (pix_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[glyph_coverage_blend_ycbcr_top] ERROR");
      $finish;
    end
  end

  // result sink with random stalls
  initial begin
    blend_t got;
    int     stall;
    res_ch.ready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, snk_max);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid === 1'b1 && res_ch.ready === 1'b1));
      got.write_enable  = res_ch.write_enable;
      got.buffer_select = res_ch.buffer_select;
      got.word_address  = res_ch.word_address;
      got.new_word      = res_ch.new_word;
      sb.check_result(got);
      @(negedge clk);
    end
  end

  // send one pixel word after a random gap, called at a falling edge
  task send_pixel(pixel_t p);
    int gap;
    gap = $urandom_range(0, src_max);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_ch.glyph_x       <= p.glyph_x;
    pix_ch.glyph_y       <= p.glyph_y;
    pix_ch.column_offset <= p.column_offset;
    pix_ch.row_offset    <= p.row_offset;
    pix_ch.coverage      <= p.coverage;
    pix_ch.old_word      <= p.old_word;
    pix_ch.valid         <= 1'b1;
    do @(posedge clk); while (!(pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1));
    sb.note_pixel(p);
    @(negedge clk);
  endtask

  task send_fields(int gx, int gy, int co, int ro, int cov, logic [WORD_W-1:0] w);
    pixel_t p;
    p.glyph_x       = COORD_W'(gx);
    p.glyph_y       = COORD_W'(gy);
    p.column_offset = OFFSET_W'(co);
    p.row_offset    = OFFSET_W'(ro);
    p.coverage      = BYTE_W'(cov);
    p.old_word      = w;
    send_pixel(p);
  endtask

  // let the pipeline empty out
  task wait_drained();
    pix_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (NUM_STAGES + 2) @(negedge clk);
  endtask

  task write_reg(cfg_reg_t idx, logic [CFG_DAT_W-1:0] val);
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk); while (!(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1));
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  // load a full font colour, height and frame; upper data bits are junk for short regs
  task apply_settings(logic [7:0] luma, logic [7:0] blue, logic [7:0] red,
                      logic [9:0] height, logic frame);
    write_reg(REG_FONT_LUMA, {2'($urandom), luma});
    write_reg(REG_FONT_BLUE_DIFF, {2'($urandom), blue});
    write_reg(REG_FONT_RED_DIFF, {2'($urandom), red});
    write_reg(REG_SCREEN_HEIGHT, height);
    write_reg(REG_FRAME_SELECT, {9'($urandom), frame});
    cfg_ch.valid <= 1'b0;
    n_settings++;
  endtask

  // mostly pixels near the visible area, some fully random words
  function pixel_t rand_pixel();
    pixel_t p;
    int     kind;
    int     cov_kind;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      p.glyph_x       = COORD_W'($urandom_range(0, SCR_W + 60) - 40);
      p.glyph_y       = COORD_W'($urandom_range(0, int'(sb.screen_height) + 30) - 24);
      p.column_offset = OFFSET_W'($urandom_range(0, 31));
      p.row_offset    = OFFSET_W'($urandom_range(0, 31));
    end else begin
      p.glyph_x       = COORD_W'($urandom);
      p.glyph_y       = COORD_W'($urandom);
      p.column_offset = OFFSET_W'($urandom);
      p.row_offset    = OFFSET_W'($urandom);
    end
    cov_kind = $urandom_range(0, 7);
    if (cov_kind == 0)
      p.coverage = '0;
    else if (cov_kind == 1)
      p.coverage = 8'hff;
    else
      p.coverage = BYTE_W'($urandom);
    p.old_word = $urandom;
    return p;
  endfunction

  initial begin
    int ph;
    int k;
    int count;
    rst                  = 1'b1;
    src_max              = 0;
    snk_max              = 0;
    n_settings           = 1;
    pix_ch.valid         = 1'b0;
    pix_ch.glyph_x       = '0;
    pix_ch.glyph_y       = '0;
    pix_ch.column_offset = '0;
    pix_ch.row_offset    = '0;
    pix_ch.coverage      = '0;
    pix_ch.old_word      = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_FONT_LUMA;
    cfg_ch.data          = '0;
    sb.reset_regs();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed pixels under the reset colour and height
    src_max = 2;
    snk_max = 2;
    send_fields(0, 0, 0, 0, 255, 32'h0000_0000);
    send_fields(0, 0, 1, 0, 255, 32'hffff_ffff);
    send_fields(0, 0, 0, 0, 0, 32'h1234_5678);
    send_fields(-1, 0, 0, 0, 200, 32'h8080_8080);
    send_fields(0, -1, 0, 0, 200, 32'h8080_8080);
    send_fields(639, 0, 0, 0, 128, 32'h1020_3040);
    send_fields(640, 0, 0, 0, 128, 32'h1020_3040);
    send_fields(0, 479, 0, 0, 99, 32'hdead_beef);
    send_fields(0, 480, 0, 0, 99, 32'hdead_beef);
    send_fields(-1024, -1024, 255, 255, 77, 32'hffff_ffff);
    send_fields(1023, 1023, 255, 255, 77, 32'h0000_0000);
    send_fields(-255, -255, 255, 255, 1, 32'hffff_ffff);
    send_fields(384, 224, 255, 255, 254, 32'h0000_0000);
    send_fields(100, 100, 128, 128, 128, 32'ha5a5_a5a5);
    send_fields(10, 10, 1, 0, 1, 32'hffff_ffff);
    send_fields(-1, 5, 1, 0, 64, 32'h5a5a_5a5a);
    send_fields(1023, 0, 0, 0, 255, 32'h0f0f_0f0f);
    send_fields(0, 1023, 0, 0, 255, 32'hf0f0_f0f0);
    send_fields(320, 240, 7, 9, 255, 32'h00ff_00ff);
    send_fields(5, 5, 3, 3, 0, 32'hffff_ffff);
    send_fields(-1024, 0, 255, 0, 255, 32'h7f80_7f80);
    wait_drained();

    // random phases over several register settings and idling patterns
    for (ph = 0; ph < 6; ph++) begin
      count = 110;
      case (ph)
        0: begin
          apply_settings(8'd0, 8'd0, 8'd0, 10'd1023, 1'b1);
          src_max = 6; snk_max = 6;
        end
        1: begin
          apply_settings(8'd255, 8'd255, 8'd255, 10'd480, 1'b0);
          src_max = 0; snk_max = 0;
        end
        2: begin
          apply_settings(8'd16, 8'd240, 8'd17, 10'd1, 1'b1);
          src_max = 6; snk_max = 0; count = 60;
        end
        3: begin
          apply_settings(8'd235, 8'd128, 8'd128, 10'd0, 1'b0);
          src_max = 0; snk_max = 6; count = 40;
        end
        4: begin
          apply_settings(8'($urandom), 8'($urandom), 8'($urandom),
                         10'($urandom_range(1, 1023)), 1'($urandom_range(0, 1)));
          src_max = 3; snk_max = 3;
        end
        default: begin
          apply_settings(8'd170, 8'd85, 8'd200, 10'd1000, 1'b1);
          src_max = 6; snk_max = 6;
        end
      endcase
      for (k = 0; k < count; k++) begin
        // hold off the sender until the pipeline is empty once mid-stream
        if (ph == 1 && k == count / 2)
          wait_drained();
        send_pixel(rand_pixel());
      end
      wait_drained();
    end

    $display("checked %0d pixel words over %0d register settings", sb.n_checked, n_settings);
    $display("%0d blended writes, %0d clipped pixels, %0d on-screen with no coverage",
             sb.n_written, sb.n_clipped, sb.n_bare);
    if (sb.errors == 0) begin
      $display("[glyph_coverage_blend_ycbcr_top] OK");
    end else begin
      $display("[glyph_coverage_blend_ycbcr_top] ERROR");
    end
    $finish;
  end

endmodule
